// File: hw/rtl/lps_pkg.sv
package lps_pkg;

    // coordinate width of endpoints and pixels
    localparam int COORD_WIDTH = 13;
    localparam int DELTA_W     = COORD_WIDTH + 1;
    localparam int DEC_W       = COORD_WIDTH + 3;

    localparam int DIM_W   = 13;
    localparam int COLOR_W = 24;
    localparam int ADDR_W  = 24;
    localparam int BYTE_W  = 8;
    localparam int CMP_W   = (COORD_WIDTH > DIM_W) ? COORD_WIDTH : DIM_W;

    localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(320);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(240);

    // config register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // color byte masks
    localparam logic [COLOR_W-1:0] GREEN_MASK = 24'h00ff00;
    localparam logic [BYTE_W-1:0]  BYTE_MASK  = 8'hff;

    // input word layout
    localparam int IN_SX_LO    = 0;
    localparam int IN_SY_LO    = IN_SX_LO + COORD_WIDTH;
    localparam int IN_EX_LO    = IN_SY_LO + COORD_WIDTH;
    localparam int IN_EY_LO    = IN_EX_LO + COORD_WIDTH;
    localparam int IN_COLOR_LO = IN_EY_LO + COORD_WIDTH;
    localparam int IN_USED     = IN_COLOR_LO + COLOR_W;
    localparam int IN_TDATA_W  = ((IN_USED + 7) / 8) * 8;

    // output word layout
    localparam int OUT_USED    = 2 * COORD_WIDTH + ADDR_W + 3 * BYTE_W;
    localparam int OUT_TDATA_W = ((OUT_USED + 7) / 8) * 8;

    // command queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_END   = 2'd1,
        PH_STEP  = 2'd2
    } t_phase;

    // classified word handed from front to back
    typedef struct packed {
        t_action                   action;
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic signed [COORD_WIDTH-1:0] ex;
        logic signed [COORD_WIDTH-1:0] ey;
        logic [COLOR_W-1:0]        color;
        logic                      steep;
        logic                      xneg;
        logic                      yneg;
        logic [DELTA_W-1:0]        major;
        logic [DELTA_W-1:0]        minor;
    } t_cmd;

    // raw pixel from the stepper
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [COLOR_W-1:0]        color;
        logic                      last;
    } t_pix;

    // finished pixel word
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [ADDR_W-1:0]         addr;
        logic [BYTE_W-1:0]         red;
        logic [BYTE_W-1:0]         green;
        logic [BYTE_W-1:0]         blue;
        logic                      on_screen;
        logic                      last;
    } t_pixout;

endpackage

// File: hw/rtl/line_pixel_stepper_core.sv
// line pixel stepper: bresenham rasterizer with frame buffer addressing
//
// input stream (s_axis): tuser selects the action, 0 loads a new line from
// the endpoints and color in tdata (no output word), 1 asks for the next
// pixel. a step with no line loaded is dropped. output stream (m_axis):
// one pixel word per step, tlast on the final pixel of the line, tuser set
// when the pixel lies on screen (address is zero otherwise).
// apb port: register 0 at 0x0 is the screen width, register 1 at 0x4 the
// screen height; write them only while no line work is in flight.
//
// throughput: one input word per clock and one pixel per clock, steady.
// path: a step word that is taken goes through the queue slot and
// bresenham stepper, the clip/multiply stage and the address add + out
// register; the y * width product in the clip stage sets the cycle time.
// reset: width 320, height 240, queue empty, no line loaded, no output.
// stall: when m_axis_tready is low under a valid pixel the stepper and pixel
// pipe hold; the 4-word command queue takes input until full, then drops tready.
module line_pixel_stepper_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // apb config
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input words
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_x, start_y, end_x, end_y, line_color, zero pad
    input  logic [lps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic                               s_axis_tuser,
    // output words
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixel_x, pixel_y, pixel_addr, red, green, blue, zero pad
    output logic [lps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // inside_res
    output logic                               m_axis_tuser,
    // last_pixel
    output logic                               m_axis_tlast
);

    logic [lps_pkg::DIM_W-1:0]   r_width, r_height;
    logic                        cfg_wr;

    lps_pkg::t_cmd               front_cmd, q_cmd;
    logic                        in_acc, q_empty, q_pop;
    logic [lps_pkg::FIFO_LW-1:0] q_level;

    lps_pkg::t_pix               step_pix;
    logic                        advance;
    lps_pkg::t_pixout            pix_out;

    // ---------------- config registers ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lps_pkg::WIDTH_RST;
            r_height <= lps_pkg::HEIGHT_RST;
        end else if (cfg_wr) begin
            // register select uses the word address bit only
            if (paddr[2] == lps_pkg::REG_WIDTH) begin
                r_width <= pwdata[lps_pkg::DIM_W-1:0];
            end else begin
                r_height <= pwdata[lps_pkg::DIM_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == lps_pkg::REG_HEIGHT) begin
            prdata = 32'(r_height);
        end else begin
            prdata = 32'(r_width);
        end
    end

    // ---------------- front: classify and queue ----------------
    assign s_axis_tready = q_level != lps_pkg::FIFO_LW'(lps_pkg::FIFO_DEPTH);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    lps_front u_front (
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_cmd   (front_cmd)
    );

    lps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (in_acc),
        .i_wdata (front_cmd),
        .i_rd    (q_pop),
        .o_rdata (q_cmd),
        .o_empty (q_empty),
        .o_level (q_level)
    );

    // ---------------- back: stepper and pixel pipe ----------------
    lps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!q_empty),
        .i_advance   (advance),
        .o_pop       (q_pop),
        .o_pix       (step_pix)
    );

    lps_pixel u_pixel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (step_pix),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_ready   (m_axis_tready),
        .o_advance (advance),
        .o_valid   (m_axis_tvalid),
        .o_out     (pix_out)
    );

    assign m_axis_tdata = lps_pkg::OUT_TDATA_W'({pix_out.blue, pix_out.green, pix_out.red,
                                                 pix_out.addr, pix_out.y, pix_out.x});
    assign m_axis_tuser = pix_out.on_screen;
    assign m_axis_tlast = pix_out.last;

    // ---------------- checks ----------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_level <= lps_pkg::FIFO_LW'(lps_pkg::FIFO_DEPTH))
        else $error("command queue over depth");

    a_offscreen_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !pix_out.on_screen |-> pix_out.addr == '0)
        else $error("off-screen pixel with nonzero address");

    a_onscreen_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && pix_out.on_screen |->
            !pix_out.x[lps_pkg::COORD_WIDTH-1] && !pix_out.y[lps_pkg::COORD_WIDTH-1])
        else $error("on-screen pixel with negative coordinate");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("stepper popped an empty queue");

endmodule

// File: hw/rtl/lps_front.sv
module lps_front (
    input  logic [lps_pkg::IN_TDATA_W-1:0] i_tdata,
    input  logic                           i_tuser,
    output lps_pkg::t_cmd                  o_cmd
);

    logic signed [lps_pkg::COORD_WIDTH-1:0] sx, sy, ex, ey;
    logic signed [lps_pkg::DELTA_W-1:0]     dx, dy;
    logic [lps_pkg::DELTA_W-1:0]            adx, ady;
    logic                                   steep;

    always_comb begin
        sx = i_tdata[lps_pkg::IN_SX_LO +: lps_pkg::COORD_WIDTH];
        sy = i_tdata[lps_pkg::IN_SY_LO +: lps_pkg::COORD_WIDTH];
        ex = i_tdata[lps_pkg::IN_EX_LO +: lps_pkg::COORD_WIDTH];
        ey = i_tdata[lps_pkg::IN_EY_LO +: lps_pkg::COORD_WIDTH];

        dx = lps_pkg::DELTA_W'(ex) - lps_pkg::DELTA_W'(sx);
        dy = lps_pkg::DELTA_W'(ey) - lps_pkg::DELTA_W'(sy);

        // magnitudes fit unsigned in the delta width
        adx   = dx[lps_pkg::DELTA_W-1] ? lps_pkg::DELTA_W'(-dx) : lps_pkg::DELTA_W'(dx);
        ady   = dy[lps_pkg::DELTA_W-1] ? lps_pkg::DELTA_W'(-dy) : lps_pkg::DELTA_W'(dy);
        steep = adx < ady;

        o_cmd.action = lps_pkg::t_action'(i_tuser);
        o_cmd.sx     = sx;
        o_cmd.sy     = sy;
        o_cmd.ex     = ex;
        o_cmd.ey     = ey;
        o_cmd.color  = i_tdata[lps_pkg::IN_COLOR_LO +: lps_pkg::COLOR_W];
        o_cmd.steep  = steep;
        o_cmd.xneg   = sx > ex;
        o_cmd.yneg   = sy > ey;
        o_cmd.major  = steep ? ady : adx;
        o_cmd.minor  = steep ? adx : ady;
    end

endmodule

// File: hw/rtl/lps_fifo.sv
module lps_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr,
    input  lps_pkg::t_cmd               i_wdata,
    input  logic                        i_rd,
    output lps_pkg::t_cmd               o_rdata,
    output logic                        o_empty,
    output logic [lps_pkg::FIFO_LW-1:0] o_level
);

    lps_pkg::t_cmd                r_mem [lps_pkg::FIFO_DEPTH];
    logic [lps_pkg::FIFO_AW-1:0]  r_wp, r_rp, n_wp, n_rp;
    logic [lps_pkg::FIFO_LW-1:0]  r_level, n_level;

    always_comb begin
        n_wp    = i_wr ? r_wp + 1'b1 : r_wp;
        n_rp    = i_rd ? r_rp + 1'b1 : r_rp;
        n_level = r_level + lps_pkg::FIFO_LW'(i_wr) - lps_pkg::FIFO_LW'(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rp];
    assign o_empty = r_level == '0;
    assign o_level = r_level;

endmodule

// File: hw/rtl/lps_back.sv
module lps_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lps_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    input  logic          i_advance,
    output logic          o_pop,
    output lps_pkg::t_pix o_pix
);

    localparam int CW = lps_pkg::COORD_WIDTH;
    localparam int DW = lps_pkg::DEC_W;

    logic                   r_active, n_active;
    lps_pkg::t_phase        r_phase, n_phase;
    logic signed [CW-1:0]   r_cur_x, r_cur_y, r_tx, r_ty;
    logic signed [CW-1:0]   n_cur_x, n_cur_y, n_tx, n_ty;
    logic signed [DW-1:0]   r_dec, n_dec;
    logic [lps_pkg::DELTA_W-1:0] r_minor, r_major, r_steps;
    logic [lps_pkg::DELTA_W-1:0] n_minor, n_major, n_steps;
    logic                   r_steep, r_xneg, r_yneg, n_steep, n_xneg, n_yneg;
    logic [lps_pkg::COLOR_W-1:0] r_color, n_color;
    lps_pkg::t_pix          r_pix, n_pix;

    logic                   pop, do_start, do_step;
    logic signed [CW-1:0]   x_adv, y_adv;
    logic signed [DW-1:0]   dec_diag, dec_axis;

    assign pop      = i_cmd_valid && i_advance;
    assign do_start = pop && (i_cmd.action == lps_pkg::ACT_START);
    assign do_step  = pop && (i_cmd.action == lps_pkg::ACT_STEP) && r_active;

    // next state of the line sequencer
    always_comb begin
        n_active = r_active;
        n_phase  = r_phase;
        if (do_start) begin
            n_active = 1'b1;
            n_phase  = lps_pkg::PH_START;
        end else if (do_step) begin
            unique case (r_phase)
                lps_pkg::PH_START: n_phase = lps_pkg::PH_END;
                lps_pkg::PH_END: begin
                    if (r_major == '0) begin
                        n_active = 1'b0;
                    end else begin
                        n_phase = lps_pkg::PH_STEP;
                    end
                end
                lps_pkg::PH_STEP: begin
                    if (r_steps == lps_pkg::DELTA_W'(1)) begin
                        n_active = 1'b0;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // datapath and pixel output
    always_comb begin
        x_adv    = r_xneg ? r_cur_x - CW'(1) : r_cur_x + CW'(1);
        y_adv    = r_yneg ? r_cur_y - CW'(1) : r_cur_y + CW'(1);
        dec_axis = r_dec + DW'({r_minor, 1'b0});
        dec_diag = r_dec + DW'({r_minor, 1'b0}) - DW'({r_major, 1'b0});

        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        n_tx    = r_tx;
        n_ty    = r_ty;
        n_dec   = r_dec;
        n_minor = r_minor;
        n_major = r_major;
        n_steps = r_steps;
        n_steep = r_steep;
        n_xneg  = r_xneg;
        n_yneg  = r_yneg;
        n_color = r_color;

        n_pix       = r_pix;
        n_pix.color = r_color;
        if (i_advance) begin
            n_pix.valid = 1'b0;
        end

        if (do_start) begin
            n_cur_x = i_cmd.sx;
            n_cur_y = i_cmd.sy;
            n_tx    = i_cmd.ex;
            n_ty    = i_cmd.ey;
            n_dec   = DW'({i_cmd.minor, 1'b0}) - DW'(i_cmd.major);
            n_minor = i_cmd.minor;
            n_major = i_cmd.major;
            n_steps = i_cmd.major;
            n_steep = i_cmd.steep;
            n_xneg  = i_cmd.xneg;
            n_yneg  = i_cmd.yneg;
            n_color = i_cmd.color;
        end else if (do_step) begin
            n_pix.valid = 1'b1;
            unique case (r_phase)
                lps_pkg::PH_START: begin
                    n_pix.x    = r_cur_x;
                    n_pix.y    = r_cur_y;
                    n_pix.last = 1'b0;
                end
                lps_pkg::PH_END: begin
                    n_pix.x    = r_tx;
                    n_pix.y    = r_ty;
                    n_pix.last = r_major == '0;
                end
                lps_pkg::PH_STEP: begin
                    // positive decision takes a diagonal step
                    if (!r_dec[DW-1] && r_dec != '0) begin
                        n_cur_x = x_adv;
                        n_cur_y = y_adv;
                        n_dec   = dec_diag;
                    end else begin
                        if (r_steep) begin
                            n_cur_y = y_adv;
                        end else begin
                            n_cur_x = x_adv;
                        end
                        n_dec = dec_axis;
                    end
                    n_steps    = r_steps - 1'b1;
                    n_pix.x    = n_cur_x;
                    n_pix.y    = n_cur_y;
                    n_pix.last = r_steps == lps_pkg::DELTA_W'(1);
                end
                default: n_pix.valid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_phase     <= lps_pkg::PH_START;
            r_pix.valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_phase     <= n_phase;
            r_pix.valid <= n_pix.valid;
        end
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_tx        <= n_tx;
        r_ty        <= n_ty;
        r_dec       <= n_dec;
        r_minor     <= n_minor;
        r_major     <= n_major;
        r_steps     <= n_steps;
        r_steep     <= n_steep;
        r_xneg      <= n_xneg;
        r_yneg      <= n_yneg;
        r_color     <= n_color;
        r_pix.x     <= n_pix.x;
        r_pix.y     <= n_pix.y;
        r_pix.color <= n_pix.color;
        r_pix.last  <= n_pix.last;
    end

    assign o_pop = pop;
    assign o_pix = r_pix;

endmodule

// File: hw/rtl/lps_pixel.sv
module lps_pixel (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lps_pkg::t_pix               i_pix,
    input  logic [lps_pkg::DIM_W-1:0]   i_width,
    input  logic [lps_pkg::DIM_W-1:0]   i_height,
    input  logic                        i_ready,
    output logic                        o_advance,
    output logic                        o_valid,
    output lps_pkg::t_pixout            o_out
);

    localparam int CW = lps_pkg::COORD_WIDTH;
    localparam int AW = lps_pkg::ADDR_W;

    logic                  advance;
    logic                  on_screen;
    logic [lps_pkg::CMP_W-1:0] xu, yu, wu, hu;
    logic [AW-1:0]         prod;

    lps_pkg::t_pix         r_s2;
    logic                  r_s2_inside;
    logic [AW-1:0]         r_s2_prod;

    logic                  r_out_valid;
    lps_pkg::t_pixout      r_out, n_out;

    assign advance = !r_out_valid || i_ready;

    // clip test and row offset
    always_comb begin
        xu        = lps_pkg::CMP_W'($unsigned(i_pix.x));
        yu        = lps_pkg::CMP_W'($unsigned(i_pix.y));
        wu        = lps_pkg::CMP_W'(i_width);
        hu        = lps_pkg::CMP_W'(i_height);
        on_screen = !i_pix.x[CW-1] && !i_pix.y[CW-1] && (xu < wu) && (yu < hu);
        prod      = AW'($unsigned(i_pix.y)) * AW'(i_width);
    end

    always_comb begin
        n_out.x         = r_s2.x;
        n_out.y         = r_s2.y;
        n_out.addr      = r_s2_inside ? AW'($unsigned(r_s2.x)) + r_s2_prod : '0;
        n_out.red       = r_s2.color[2*lps_pkg::BYTE_W +: lps_pkg::BYTE_W] & lps_pkg::BYTE_MASK;
        n_out.green     = lps_pkg::BYTE_W'((r_s2.color & lps_pkg::GREEN_MASK) >> lps_pkg::BYTE_W);
        n_out.blue      = r_s2.color[lps_pkg::BYTE_W-1:0] & lps_pkg::BYTE_MASK;
        n_out.on_screen = r_s2_inside;
        n_out.last      = r_s2.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s2.valid  <= i_pix.valid;
            r_out_valid <= r_s2.valid;
        end
        if (advance) begin
            r_s2.x      <= i_pix.x;
            r_s2.y      <= i_pix.y;
            r_s2.color  <= i_pix.color;
            r_s2.last   <= i_pix.last;
            r_s2_inside <= on_screen;
            r_s2_prod   <= prod;
            r_out       <= n_out;
        end
    end

    assign o_advance = advance;
    assign o_valid   = r_out_valid;
    assign o_out     = r_out;

endmodule

// File: test/testbench.sv
module testbench;

    import lps_pkg::*;

    // output word layout, lowest bit first
    localparam int POS_X     = 0;
    localparam int POS_Y     = POS_X + COORD_WIDTH;
    localparam int POS_ADDR  = POS_Y + COORD_WIDTH;
    localparam int POS_RED   = POS_ADDR + ADDR_W;
    localparam int POS_GREEN = POS_RED + BYTE_W;
    localparam int POS_BLUE  = POS_GREEN + BYTE_W;

    localparam int DIM_MASK      = (1 << DIM_W) - 1;
    localparam int SETTLE_CYCLES = 16;   // well past the pixel pipeline latency
    localparam int HOLD_CYCLES   = 400;  // long output back-pressure stretch
    localparam int PHASE_WORDS   = 135;
    localparam int MAX_PRINTS    = 40;

    // one input word as the stepper sees it
    typedef struct packed {
        t_action                       action;
        logic signed [COORD_WIDTH-1:0] sx;
        logic signed [COORD_WIDTH-1:0] sy;
        logic signed [COORD_WIDTH-1:0] ex;
        logic signed [COORD_WIDTH-1:0] ey;
        logic [COLOR_W-1:0]            color;
    } line_word_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // start_x, start_y, end_x, end_y, line_color, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // action
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // pixel_x, pixel_y, pixel_addr, red, green, blue, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // inside_res
    logic                   m_axis_tuser;
    // last_pixel
    logic                   m_axis_tlast;

    line_pixel_stepper_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // words waiting for the driver, pixels waiting for the monitor
    line_word_t line_queue[$];
    t_pixout    pixel_queue[$];

    // screen size as the stepper should currently see it
    int scr_w = 320;
    int scr_h = 240;

    // rasterizer state, mirrors the block after reset
    bit     ln_active = 1'b0;
    t_phase ln_phase = PH_START;
    int     cur_x = 0;
    int     cur_y = 0;
    int     tgt_x = 0;
    int     tgt_y = 0;
    int     decision = 0;
    int     minor_d = 0;
    int     major_d = 0;
    int     steps_left = 0;
    bit     ln_steep = 1'b0;
    bit     ln_xneg = 1'b0;
    bit     ln_yneg = 1'b0;
    logic [COLOR_W-1:0] ln_color = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit pressure_req = 1'b0;
    logic hold_output = 1'b0;

    int errors = 0;
    int items_queued = 0;
    int lines_loaded = 0;
    int pixels_checked = 0;
    int pixels_on_screen = 0;
    int line_ends = 0;
    int settings_used = 1;

    line_word_t word_held;
    t_pixout    next_pixel;
    t_pixout    got;
    t_pixout    want;

    task automatic flag_mismatch(string what, longint seen, longint wanted);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at pixel %0d: %s got %0d expected %0d",
                     pixels_checked, what, seen, wanted);
    endtask

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int clamp_coord(int v);
        int lim;
        lim = 1 << (COORD_WIDTH - 1);
        if (v < -lim)
            return -lim;
        if (v > lim - 1)
            return lim - 1;
        return v;
    endfunction

    // clip test, frame buffer address and color split of one pixel
    function automatic t_pixout make_pixel(int x, int y, bit fin);
        t_pixout p;
        p.x         = x[COORD_WIDTH-1:0];
        p.y         = y[COORD_WIDTH-1:0];
        p.on_screen = (x >= 0) && (x < scr_w) && (y >= 0) && (y < scr_h);
        p.addr      = p.on_screen ? ADDR_W'(x + y * scr_w) : '0;
        p.red       = ln_color[23:16];
        p.green     = BYTE_W'((ln_color & GREEN_MASK) >> 8);
        p.blue      = ln_color[7:0] & BYTE_MASK;
        p.last      = fin;
        return p;
    endfunction

    // advance the rasterizer by one word, returns 1 when a pixel comes out
    function automatic bit step_line(line_word_t w, output t_pixout px);
        int dx, dy;
        bit fin;
        px = '0;
        if (w.action == ACT_START) begin
            dx         = int'(w.ex) - int'(w.sx);
            dy         = int'(w.ey) - int'(w.sy);
            ln_steep   = iabs(dx) < iabs(dy);
            major_d    = ln_steep ? iabs(dy) : iabs(dx);
            minor_d    = ln_steep ? iabs(dx) : iabs(dy);
            decision   = 2 * minor_d - major_d;
            steps_left = major_d;
            ln_xneg    = w.sx > w.ex;
            ln_yneg    = w.sy > w.ey;
            cur_x      = w.sx;
            cur_y      = w.sy;
            tgt_x      = w.ex;
            tgt_y      = w.ey;
            ln_color   = w.color;
            ln_phase   = PH_START;
            ln_active  = 1'b1;
            lines_loaded++;
            return 1'b0;
        end
        // a step with no line loaded is simply dropped
        if (!ln_active)
            return 1'b0;
        case (ln_phase)
            PH_START: begin
                px       = make_pixel(cur_x, cur_y, 1'b0);
                ln_phase = PH_END;
            end
            PH_END: begin
                // zero-length major axis ends on the end point
                fin = major_d == 0;
                px  = make_pixel(tgt_x, tgt_y, fin);
                if (fin)
                    ln_active = 1'b0;
                else
                    ln_phase = PH_STEP;
            end
            default: begin
                if (decision > 0) begin
                    cur_x    += ln_xneg ? -1 : 1;
                    cur_y    += ln_yneg ? -1 : 1;
                    decision += 2 * (minor_d - major_d);
                end else begin
                    if (ln_steep)
                        cur_y += ln_yneg ? -1 : 1;
                    else
                        cur_x += ln_xneg ? -1 : 1;
                    decision += 2 * minor_d;
                end
                steps_left--;
                fin = steps_left <= 0;
                px  = make_pixel(cur_x, cur_y, fin);
                if (fin)
                    ln_active = 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic queue_step();
        line_word_t w;
        w        = $bits(line_word_t)'({$urandom(), $urandom(), $urandom()});
        w.action = ACT_STEP;
        line_queue.push_back(w);
        items_queued++;
    endtask

    task automatic queue_line(int sx, int sy, int ex, int ey, int unsigned color,
                              int n_steps);
        line_word_t w;
        w.action = ACT_START;
        w.sx     = COORD_WIDTH'(clamp_coord(sx));
        w.sy     = COORD_WIDTH'(clamp_coord(sy));
        w.ex     = COORD_WIDTH'(clamp_coord(ex));
        w.ey     = COORD_WIDTH'(clamp_coord(ey));
        w.color  = COLOR_W'(color);
        line_queue.push_back(w);
        items_queued++;
        repeat (n_steps) queue_step();
    endtask

    // mostly short lines near the screen, run to the end; a few are cut
    // short, overrun with idle steps, or span the whole coordinate range
    task automatic queue_random_line(int span_x, int span_y);
        int sx, sy, ex, ey, len, full, n, roll;
        roll = $urandom_range(99);
        if (roll < 6) begin
            queue_line(int'($urandom_range(8191)) - 4096, int'($urandom_range(8191)) - 4096,
                       int'($urandom_range(8191)) - 4096, int'($urandom_range(8191)) - 4096,
                       $urandom(), $urandom_range(4));
        end else begin
            len  = ($urandom_range(9) == 0) ? 40 : 10;
            sx   = clamp_coord(int'($urandom_range(span_x + 8)) - 4);
            sy   = clamp_coord(int'($urandom_range(span_y + 8)) - 4);
            ex   = clamp_coord(sx + int'($urandom_range(2 * len)) - len);
            ey   = clamp_coord(sy + int'($urandom_range(2 * len)) - len);
            full = 2 + ((iabs(ex - sx) > iabs(ey - sy)) ? iabs(ex - sx) : iabs(ey - sy));
            roll = $urandom_range(9);
            if (roll == 0)
                n = $urandom_range(full - 1);
            else if (roll == 1)
                n = full + $urandom_range(3, 1);
            else
                n = full;
            queue_line(sx, sy, ex, ey, $urandom(), n);
        end
    endtask

    task automatic fill_random(int n_words, int span_x, int span_y);
        int target;
        target = items_queued + n_words;
        while (items_queued < target)
            queue_random_line(span_x, span_y);
    endtask

    // apb write: setup cycle, then access until pready
    task automatic write_reg(logic idx, int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~DIM_MASK) | (value & DIM_MASK);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WIDTH)
            scr_w = value & DIM_MASK;
        else
            scr_h = value & DIM_MASK;
    endtask

    // all words taken, all pixels back, then let the pipe settle
    task automatic wait_idle();
        while (line_queue.size() != 0 || s_axis_tvalid || pixel_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(int w, int h, int send_pct, int recv_pct, bit squeeze);
        wait_idle();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        settings_used++;
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        if (squeeze) begin
            // long line so the sender keeps offering steps during the hold
            queue_line(0, 0, 100, 37, $urandom(), 102);
            pressure_req = 1'b1;
        end
        fill_random(PHASE_WORDS, w, h);
    endtask

    // input driver: holds a word until taken, then maybe idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid && step_line(word_held, next_pixel))
                pixel_queue.push_back(next_pixel);
            if (line_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                word_held = line_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= word_held.action;
                s_axis_tdata  <= IN_TDATA_W'({word_held.color, word_held.ey,
                                              word_held.ex, word_held.sy, word_held.sx});
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output monitor: checks each pixel word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.x         = m_axis_tdata[POS_X +: COORD_WIDTH];
                got.y         = m_axis_tdata[POS_Y +: COORD_WIDTH];
                got.addr      = m_axis_tdata[POS_ADDR +: ADDR_W];
                got.red       = m_axis_tdata[POS_RED +: BYTE_W];
                got.green     = m_axis_tdata[POS_GREEN +: BYTE_W];
                got.blue      = m_axis_tdata[POS_BLUE +: BYTE_W];
                got.on_screen = m_axis_tuser;
                got.last      = m_axis_tlast;
                if (pixel_queue.size() == 0) begin
                    flag_mismatch("pixel with nothing expected, x", got.x, 0);
                end else begin
                    want = pixel_queue.pop_front();
                    if (got.x !== want.x)
                        flag_mismatch("pixel_x", got.x, want.x);
                    if (got.y !== want.y)
                        flag_mismatch("pixel_y", got.y, want.y);
                    if (got.addr !== want.addr)
                        flag_mismatch("pixel_addr", got.addr, want.addr);
                    if (got.red !== want.red)
                        flag_mismatch("red", got.red, want.red);
                    if (got.green !== want.green)
                        flag_mismatch("green", got.green, want.green);
                    if (got.blue !== want.blue)
                        flag_mismatch("blue", got.blue, want.blue);
                    if (got.on_screen !== want.on_screen)
                        flag_mismatch("inside_res", got.on_screen, want.on_screen);
                    if (got.last !== want.last)
                        flag_mismatch("last_pixel", got.last, want.last);
                    pixels_on_screen += want.on_screen;
                    line_ends        += want.last;
                end
                pixels_checked++;
            end
            m_axis_tready <= !hold_output && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one long output hold so the command queue fills and input stalls
    initial begin
        wait (pressure_req);
        @(posedge i_clk);
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines at the reset screen size of 320 x 240
        queue_step();                                          // nothing loaded yet
        queue_line(0, 0, 0, 0, 24'hffffff, 3);                 // zero length, extra step
        queue_line(318, 5, 321, 6, 24'h000000, 5);             // runs off right edge
        queue_line(2, 238, 1, 241, 24'h00ff00, 5);             // steep, crosses bottom
        queue_line(-4096, -4096, 4095, 4095, 24'h5a5a5a, 2);   // extremes, cut short
        queue_line(4095, -4096, -4096, 4095, 24'ha5a5a5, 1);   // restart while active
        queue_line(9, 9, 7, 7, 24'h123456, 4);                 // diagonal, both negative

        run_phase(0, 5, 87, 0, 1'b0);          // zero width: nothing on screen
        run_phase(DIM_MASK, DIM_MASK, 0, 87, 1'b0);  // widest screen, address wrap
        run_phase(1, 1, 34, 34, 1'b0);         // single pixel screen
        run_phase(4096, 4096, 0, 0, 1'b1);     // full rate plus long output hold
        run_phase($urandom_range(64, 16), $urandom_range(48, 8), 34, 34, 1'b0);

        wait_idle();
        if (pixel_queue.size() != 0)
            flag_mismatch("pixels never delivered", 0, pixel_queue.size());
        $display("covered %0d words, %0d lines, %0d screen sizes",
                 items_queued, lines_loaded, settings_used);
        $display("checked %0d pixels, %0d on screen, %0d line ends",
                 pixels_checked, pixels_on_screen, line_ends);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("timeout with %0d words unsent, %0d pixels outstanding",
                 line_queue.size(), pixel_queue.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
